### sv/mseu_pkg.sv
// shared types, constants and codes of the mips subset execute unit
`default_nettype none
package mseu_pkg;

  localparam int unsigned DUMP_REGS = 26;
  localparam int unsigned XLEN      = 32;
  localparam int unsigned RIDX_W    = 5;
  localparam int unsigned STEP_W    = 2;

  localparam logic [XLEN-1:0]   HALT_WORD = 32'hFFFF_FFFF;
  localparam logic [RIDX_W-1:0] DUMP_LAST = RIDX_W'(DUMP_REGS - 1);

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_J     = 6'b000010;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_BNE   = 6'b000101;
  localparam logic [5:0] OP_ADDI  = 6'b001000;
  localparam logic [5:0] OP_SLTI  = 6'b001010;
  localparam logic [5:0] OP_DUMP  = 6'b111111;

  // r-type funct codes
  localparam logic [5:0] FN_SLL = 6'b000000;
  localparam logic [5:0] FN_SRL = 6'b000010;
  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;

  // result status codes
  localparam logic [2:0] ST_EXEC    = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_BAD_OP  = 3'd2;
  localparam logic [2:0] ST_BAD_FN  = 3'd3;
  localparam logic [2:0] ST_DUMP    = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  // microcode addresses
  localparam logic [STEP_W-1:0] STEP_FETCH = 2'd0;
  localparam logic [STEP_W-1:0] STEP_EXEC  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_DRD   = 2'd2;
  localparam logic [STEP_W-1:0] STEP_DOUT  = 2'd3;

  typedef enum logic [1:0] {
    C_NEVER    = 2'd0,
    C_NO_INPUT = 2'd1,
    C_NOT_DUMP = 2'd2,
    C_MORE     = 2'd3
  } cond_t;

  // one microcode control word
  typedef struct packed {
    logic              in_en;
    logic              exec_en;
    logic              drd_en;
    logic              dout_en;
    logic              wait_out;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic in_fire;
    logic is_dump;
    logic more;
    logic stall;
  } seq_stat_t;

  // outcome of one instruction
  typedef struct packed {
    logic [XLEN-1:0]   next_pc;
    logic [2:0]        status;
    logic              we;
    logic [RIDX_W-1:0] dest;
    logic [XLEN-1:0]   value;
    logic              halt;
    logic              is_dump;
  } exec_t;

endpackage
`default_nettype wire

### sv/mseu_regfile.sv
// 32 x 32 register file, one write port, two registered read ports, reset by valid bits
`default_nettype none
module mseu_regfile (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          we,
  input  wire  [mseu_pkg::RIDX_W-1:0]  waddr,
  input  wire  [mseu_pkg::XLEN-1:0]    wdata,
  input  wire                          rd_en,
  input  wire  [mseu_pkg::RIDX_W-1:0]  raddr_a,
  input  wire  [mseu_pkg::RIDX_W-1:0]  raddr_b,
  output logic [mseu_pkg::XLEN-1:0]    rdata_a,
  output logic [mseu_pkg::XLEN-1:0]    rdata_b
);
  import mseu_pkg::*;

  localparam int unsigned DEPTH = 1 << RIDX_W;

  logic [XLEN-1:0]  mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [XLEN-1:0]  rdata_a_r;
  logic [XLEN-1:0]  rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_a_r <= valid_r[raddr_a] ? mem[raddr_a] : '0;
      rdata_b_r <= valid_r[raddr_b] ? mem[raddr_b] : '0;
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule
`default_nettype wire

### sv/mseu_alu.sv
// instruction decode and execute: result value, next pc and status
`default_nettype none
module mseu_alu (
  input  wire  [mseu_pkg::XLEN-1:0] instr,
  input  wire  [mseu_pkg::XLEN-1:0] pc,
  input  wire  [mseu_pkg::XLEN-1:0] a,
  input  wire  [mseu_pkg::XLEN-1:0] b,
  input  wire                       halted,
  output mseu_pkg::exec_t           res
);
  import mseu_pkg::*;

  logic [5:0]        op;
  logic [5:0]        fn;
  logic [4:0]        sa;
  logic [XLEN-1:0]   simm;
  logic [XLEN-1:0]   seq;

  assign op   = instr[31:26];
  assign fn   = instr[5:0];
  assign sa   = instr[10:6];
  assign simm = {{16{instr[15]}}, instr[15:0]};
  assign seq  = pc + 32'd4;

  always_comb begin
    res         = '0;
    res.next_pc = seq;
    res.status  = ST_EXEC;
    if (halted) begin
      res.next_pc = pc;
      res.status  = ST_IGNORED;
    end else if (instr == HALT_WORD) begin
      res.next_pc = pc;
      res.status  = ST_HALT;
      res.halt    = 1'b1;
    end else begin
      unique case (op) inside
        OP_RTYPE: begin
          res.we   = 1'b1;
          res.dest = instr[15:11];
          unique case (fn)
            FN_ADD:  res.value = a + b;
            FN_SUB:  res.value = a - b;
            FN_SLL:  res.value = b << sa;
            FN_SRL:  res.value = b >> sa;
            default: begin
              res.we     = 1'b0;
              res.dest   = '0;
              res.status = ST_BAD_FN;
            end
          endcase
        end
        OP_J: res.next_pc = {4'b0000, instr[25:0], 2'b00};
        OP_BEQ, OP_BNE: begin
          if ((op == OP_BEQ) == (a == b)) begin
            res.next_pc = seq + {simm[29:0], 2'b00};
          end
        end
        OP_ADDI: begin
          res.we    = 1'b1;
          res.dest  = instr[20:16];
          res.value = a + simm;
        end
        OP_SLTI: begin
          res.we    = 1'b1;
          res.dest  = instr[20:16];
          res.value = {31'd0, ($signed(a) < $signed(simm))};
        end
        OP_DUMP: begin
          res.status  = ST_DUMP;
          res.is_dump = 1'b1;
        end
        default: res.status = ST_BAD_OP;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/mseu_sequencer.sv
// microcode rom and step counter with conditional jumps
`default_nettype none
module mseu_sequencer (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mseu_pkg::seq_stat_t stat,
  output mseu_pkg::ctl_t      ctl
);
  import mseu_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              jump;

  // program: fetch, execute, then for dump a read / emit loop
  always_comb begin
    unique case (step_r)
      STEP_FETCH: ctl = '{in_en: 1'b1, exec_en: 1'b0, drd_en: 1'b0, dout_en: 1'b0,
                          wait_out: 1'b0, cond: C_NO_INPUT, target: STEP_FETCH};
      STEP_EXEC:  ctl = '{in_en: 1'b0, exec_en: 1'b1, drd_en: 1'b0, dout_en: 1'b0,
                          wait_out: 1'b1, cond: C_NOT_DUMP, target: STEP_FETCH};
      STEP_DRD:   ctl = '{in_en: 1'b0, exec_en: 1'b0, drd_en: 1'b1, dout_en: 1'b0,
                          wait_out: 1'b0, cond: C_NEVER, target: STEP_FETCH};
      STEP_DOUT:  ctl = '{in_en: 1'b0, exec_en: 1'b0, drd_en: 1'b0, dout_en: 1'b1,
                          wait_out: 1'b1, cond: C_MORE, target: STEP_DRD};
      default:    ctl = '{in_en: 1'b0, exec_en: 1'b0, drd_en: 1'b0, dout_en: 1'b0,
                          wait_out: 1'b0, cond: C_NEVER, target: STEP_FETCH};
    endcase
  end

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:    jump = 1'b0;
      C_NO_INPUT: jump = !stat.in_fire;
      C_NOT_DUMP: jump = !stat.is_dump;
      C_MORE:     jump = stat.more;
      default:    jump = 1'b0;
    endcase
  end

  always_comb begin
    if (ctl.wait_out && stat.stall) begin
      step_nxt = step_r;
    end else if (jump) begin
      step_nxt = ctl.target;
    end else begin
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/mips_subset_execute_unit_top.sv
// top level of the mips subset execute unit: sequencer, register file, alu, output register
`default_nettype none
// usage
//   in_*   : one 32-bit instruction word per handshake, fetched at the current pc
//   out_*  : result words; tdata carries pc_of_instr, next_pc, status, reg_written,
//            dest_reg, dest_value; tlast marks the final word of an instruction
//   cfg_*  : writing start_pc also loads the program counter; write only when idle
// timing
//   a microcoded sequencer runs fetch -> execute; the register file read is
//   registered, so an ordinary instruction's operands are read at acceptance
//   and its result is loaded into the output register by the execute step; the
//   next word is taken only after that execute step is done
//   the dump opcode walks registers 0 .. DUMP_REGS-1 through the read port,
//   reading each entry in the read step and emitting it in the emit step
// reset
//   synchronous, active low; register file reads as zero, pc = 0, not halted
// back pressure
//   a single output register holds the result; while it is full and out_tready
//   is low the execute and dump-emit steps wait, and a new instruction is still
//   accepted in the fetch step
module mips_subset_execute_unit_top (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [31:0]  in_tdata,   // [31:0] instr
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [111:0] out_tdata,  // [31:0] pc_of_instr, [63:32] next_pc, [66:64] status,
                                   // [67] reg_written, [72:68] dest_reg, [104:73] dest_value
  output logic         out_tlast,
  input  wire          cfg_we,
  input  wire  [31:0]  cfg_wdata   // start_pc
);
  import mseu_pkg::*;

  ctl_t      ctl;
  seq_stat_t stat;
  exec_t     ex;

  logic [XLEN-1:0]   instr_r;
  logic [XLEN-1:0]   pc_r;
  logic [XLEN-1:0]   ipc_r;
  logic              halted_r;
  logic [RIDX_W-1:0] idx_r;

  // output register
  logic              ov_r;
  logic [XLEN-1:0]   o_pc_r;
  logic [XLEN-1:0]   o_npc_r;
  logic [2:0]        o_status_r;
  logic              o_wr_r;
  logic [RIDX_W-1:0] o_dest_r;
  logic [XLEN-1:0]   o_value_r;
  logic              o_last_r;

  logic              in_fire;
  logic              stall;
  logic              exec_go;
  logic              dout_go;
  logic              emit_exec;
  logic              load_out;
  logic              rf_we;
  logic              rf_rd_en;
  logic [RIDX_W-1:0] rf_raddr_a;
  logic [XLEN-1:0]   rdata_a;
  logic [XLEN-1:0]   rdata_b;

  assign in_tready = ctl.in_en;
  assign in_fire   = in_tvalid && in_tready;
  assign stall     = ov_r && !out_tready;
  assign exec_go   = ctl.exec_en && !stall;
  assign dout_go   = ctl.dout_en && !stall;
  assign emit_exec = exec_go && !ex.is_dump;
  assign load_out  = emit_exec || dout_go;
  assign rf_we     = exec_go && ex.we;

  assign stat.in_fire = in_fire;
  assign stat.is_dump = ex.is_dump;
  assign stat.more    = (idx_r != DUMP_LAST);
  assign stat.stall   = stall;

  mseu_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  // port a serves rs in fetch and the dump index in the dump loop
  assign rf_rd_en   = in_fire || ctl.drd_en;
  assign rf_raddr_a = ctl.drd_en ? idx_r : in_tdata[25:21];

  mseu_regfile u_rf (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (rf_we),
    .waddr   (ex.dest),
    .wdata   (ex.value),
    .rd_en   (rf_rd_en),
    .raddr_a (rf_raddr_a),
    .raddr_b (in_tdata[20:16]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mseu_alu u_alu (
    .instr  (instr_r),
    .pc     (pc_r),
    .a      (rdata_a),
    .b      (rdata_b),
    .halted (halted_r),
    .res    (ex)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      instr_r <= in_tdata;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      halted_r <= 1'b0;
      idx_r    <= '0;
      ipc_r    <= '0;
    end else begin
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end else if (exec_go) begin
        pc_r <= ex.next_pc;
      end
      if (exec_go) begin
        halted_r <= halted_r || ex.halt;
        idx_r    <= '0;
        ipc_r    <= pc_r;
      end else if (dout_go) begin
        idx_r <= idx_r + RIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_out) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_exec) begin
      o_pc_r     <= pc_r;
      o_npc_r    <= ex.next_pc;
      o_status_r <= ex.status;
      o_wr_r     <= ex.we;
      o_dest_r   <= ex.dest;
      o_value_r  <= ex.value;
      o_last_r   <= 1'b1;
    end else if (dout_go) begin
      o_pc_r     <= ipc_r;
      o_npc_r    <= pc_r;
      o_status_r <= ST_DUMP;
      o_wr_r     <= 1'b0;
      o_dest_r   <= idx_r;
      o_value_r  <= rdata_a;
      o_last_r   <= (idx_r == DUMP_LAST);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {7'd0, o_value_r, o_dest_r, o_wr_r, o_status_r, o_npc_r, o_pc_r};

  // once halted, only reset leaves the halt
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag dropped without reset");

  // while halted the pc moves only by a configuration write
  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && !cfg_we) |=> $stable(pc_r))
    else $error("pc changed while halted");

  // a register write always shows up as a result word marking the write
  a_write_reported: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |=> (ov_r && o_wr_r && o_last_r))
    else $error("register write without matching result");

  // input is taken only when the output side is not being loaded
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !load_out)
    else $error("input accepted during result load");

  // dump words never end early
  a_dump_last: assert property (@(posedge clk) disable iff (!rst_n)
    (dout_go && idx_r != DUMP_LAST) |=> !o_last_r)
    else $error("dump marked last too early");

endmodule
`default_nettype wire

### tb/mips_subset_execute_unit_top_tb.sv
// self-checking testbench for the mips subset execute unit: directed, random, stall and halt runs
module mips_subset_execute_unit_top_tb;
  import mseu_pkg::*;

  localparam int WATCHDOG_LIMIT     = 5000; // quiet cycles before the run is declared hung
  localparam int HOLD_CYCLES        = 300;  // long receiver hold-off in the stall test
  localparam int TAIL_CYCLES        = 64;   // longer than a full dump walk
  localparam int RANDOM_PHASE_WORDS = 49;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // one expected result word
  typedef struct {
    logic [XLEN-1:0]   pc_of_instr;
    logic [XLEN-1:0]   next_pc;
    logic [2:0]        status;
    logic              reg_written;
    logic [RIDX_W-1:0] dest_reg;
    logic [XLEN-1:0]   dest_value;
    logic              last;
  } retire_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;    // [31:0] instr
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;        // [31:0] pc_of_instr, [63:32] next_pc, [66:64] status,
                                  // [67] reg_written, [72:68] dest_reg, [104:73] dest_value
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;   // start_pc

  // architectural shadow of the block
  logic [XLEN-1:0] gpr [32];
  logic [XLEN-1:0] arch_pc;
  bit              is_halted;
  retire_t         retire_q [$];  // results still owed by the block, oldest first

  int       mismatches = 0;
  int       quiet_cycles = 0;
  rx_mode_t rx_mode = RX_RANDOM;
  bit       tx_bursty = 1'b1;
  int       burst_left = 0;
  int       hold_reqs = 0;        // bumped by a test to ask the receiver for a long hold-off
  int       hold_served = 0;
  int       hold_left = 0;
  int       rx_tick = 0;

  mips_subset_execute_unit_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // instruction encoders
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sa, logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // ---------------------------------------------------------------------------
  // execution predictor: updates the shadow state and queues the owed results
  // ---------------------------------------------------------------------------
  function automatic void owe_result(logic [31:0] pc, logic [31:0] npc, logic [2:0] st,
                                     logic wr, logic [4:0] dreg, logic [31:0] dval,
                                     logic lst);
    retire_t r;
    r.pc_of_instr = pc;
    r.next_pc     = npc;
    r.status      = st;
    r.reg_written = wr;
    r.dest_reg    = dreg;
    r.dest_value  = dval;
    r.last        = lst;
    retire_q.push_back(r);
  endfunction

  function automatic void retire_instr(logic [31:0] w);
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [31:0] simm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc;
    logic [31:0] seq;
    logic [31:0] v;
    op   = w[31:26];
    rs   = w[25:21];
    rt   = w[20:16];
    rd   = w[15:11];
    sa   = w[10:6];
    fn   = w[5:0];
    simm = {{16{w[15]}}, w[15:0]};
    a    = gpr[rs];
    b    = gpr[rt];
    pc   = arch_pc;
    seq  = pc + 32'd4;

    // locked up: everything is answered and nothing changes
    if (is_halted) begin
      owe_result(pc, pc, ST_IGNORED, 1'b0, '0, '0, 1'b1);
      return;
    end
    if (w == HALT_WORD) begin
      is_halted = 1'b1;
      owe_result(pc, pc, ST_HALT, 1'b0, '0, '0, 1'b1);
      return;
    end

    arch_pc = seq;
    case (op) inside
      OP_RTYPE: begin
        case (fn)
          FN_ADD: v = a + b;
          FN_SUB: v = a - b;
          FN_SLL: v = b << sa;    // shifts take rt, rs is ignored
          FN_SRL: v = b >> sa;
          default: begin
            owe_result(pc, seq, ST_BAD_FN, 1'b0, '0, '0, 1'b1);
            return;
          end
        endcase
        gpr[rd] = v;
        owe_result(pc, seq, ST_EXEC, 1'b1, rd, v, 1'b1);
      end
      OP_J: begin
        arch_pc = {4'd0, w[25:0], 2'b00};  // upper pc bits dropped
        owe_result(pc, arch_pc, ST_EXEC, 1'b0, '0, '0, 1'b1);
      end
      OP_BEQ, OP_BNE: begin
        if ((op == OP_BEQ) == (a == b)) arch_pc = seq + (simm << 2);
        owe_result(pc, arch_pc, ST_EXEC, 1'b0, '0, '0, 1'b1);
      end
      OP_ADDI: begin
        v = a + simm;
        gpr[rt] = v;
        owe_result(pc, seq, ST_EXEC, 1'b1, rt, v, 1'b1);
      end
      OP_SLTI: begin
        v = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
        gpr[rt] = v;
        owe_result(pc, seq, ST_EXEC, 1'b1, rt, v, 1'b1);
      end
      OP_DUMP: begin
        for (int i = 0; i < DUMP_REGS; i++)
          owe_result(pc, seq, ST_DUMP, 1'b0, 5'(i), gpr[i], i == DUMP_REGS - 1);
      end
      default: owe_result(pc, seq, ST_BAD_OP, 1'b0, '0, '0, 1'b1);
    endcase
  endfunction

  // mostly well-formed instructions with random content, some malformed, some noise
  function automatic logic [31:0] random_instr();
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [31:0] w;
    int          pick;
    pick = $urandom_range(0, 99);
    rs   = 5'($urandom_range(0, 31));
    // same register on both sides now and then so beq/bne see equal operands
    rt   = ($urandom_range(0, 3) == 0) ? rs : 5'($urandom_range(0, 31));
    w    = $urandom();
    if (pick < 40) begin
      fn = (pick < 10) ? FN_ADD : (pick < 20) ? FN_SUB : (pick < 30) ? FN_SLL : FN_SRL;
      w  = {OP_RTYPE, rs, rt, w[15:6], fn};
    end else if (pick < 56) begin
      w = enc_i(OP_ADDI, rs, rt, w[15:0]);
    end else if (pick < 64) begin
      w = enc_i(OP_SLTI, rs, rt, w[15:0]);
    end else if (pick < 71) begin
      w = enc_i(OP_BEQ, rs, rt, w[15:0]);
    end else if (pick < 78) begin
      w = enc_i(OP_BNE, rs, rt, w[15:0]);
    end else if (pick < 82) begin
      w = {OP_J, w[25:0]};
    end else if (pick < 87) begin
      do op = 6'($urandom_range(0, 63));
      while (op inside {OP_RTYPE, OP_J, OP_BEQ, OP_BNE, OP_ADDI, OP_SLTI, OP_DUMP});
      w = {op, w[25:0]};
    end else if (pick < 92) begin
      do fn = 6'($urandom_range(0, 63));
      while (fn inside {FN_SLL, FN_SRL, FN_ADD, FN_SUB});
      w = {OP_RTYPE, w[25:6], fn};
    end else if (pick < 95) begin
      w = {OP_DUMP, w[25:0]};
    end
    // the halt word is only sent on purpose
    if (w == HALT_WORD) w[0] = 1'b0;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: bursts of random length with random gaps, or back to back
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] w);
    int gap;
    @(negedge clk);
    if (tx_bursty && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (in_tready !== 1'b1);
    retire_instr(w);
  endtask

  // drop valid right after the last word so it is not taken twice
  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (retire_q.size() != 0) @(posedge clk);
  endtask

  // only called with the block idle; the write also reloads the pc
  task automatic load_start_pc(input logic [31:0] addr);
    @(negedge clk);
    cfg_wdata <= addr;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    arch_pc = addr;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: its own stall pattern, plus a long counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_tick++;
    if (hold_reqs != hold_served) begin
      hold_served = hold_reqs;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_tready <= 1'b1;
        RX_RANDOM:  out_tready <= ($urandom_range(0, 3) != 0);
        default:    out_tready <= ((rx_tick % 9) >= 4);  // stalled while the tick modulo 9 is below 4, else ready
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted word against the oldest owed result
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    retire_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (retire_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        mismatches++;
      end else begin
        want = retire_q.pop_front();
        check_field("pc_of_instr", want.pc_of_instr, out_tdata[31:0]);
        check_field("next_pc",     want.next_pc,     out_tdata[63:32]);
        check_field("status",      want.status,      out_tdata[66:64]);
        check_field("reg_written", want.reg_written, out_tdata[67]);
        check_field("dest_reg",    want.dest_reg,    out_tdata[72:68]);
        check_field("dest_value",  want.dest_value,  out_tdata[104:73]);
        check_field("tdata pad",   '0,               out_tdata[111:105]);
        check_field("last",        want.last,        out_tlast);
      end
    end
  end

  // hang detection: nothing moving on any port for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("mips_subset_execute_unit_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every operation at least once, field extremes, r0 writable, wrap, shifts of rt, branch
  // both ways, jump extremes, bad opcode and funct, one dump; start_pc at reset value
  task automatic test_directed_ops();
    rx_mode   = RX_RANDOM;
    tx_bursty = 1'b1;
    send_word(enc_i(OP_ADDI, 0, 1, 16'h7FFF));          // largest positive imm
    send_word(enc_i(OP_ADDI, 0, 2, 16'h8000));          // most negative imm
    send_word(enc_i(OP_ADDI, 0, 0, 16'h0005));          // r0 is an ordinary register
    send_word(enc_r(0, 1, 3, 0, FN_ADD));
    send_word(enc_r(2, 1, 4, 0, FN_SUB));
    send_word(enc_r(31, 2, 5, 31, FN_SLL));             // rs must not matter
    send_word(enc_r(1, 2, 6, 31, FN_SRL));              // logical, top bit only
    send_word(enc_r(2, 2, 7, 0, FN_SRL));               // shift by zero
    send_word(enc_r(0, 6, 10, 31, FN_SLL));             // r10 = 0x80000000
    send_word(enc_r(10, 6, 11, 0, FN_SUB));             // wraps to 0x7fffffff
    send_word(enc_r(11, 11, 12, 0, FN_ADD));            // wraps past the sign
    send_word(enc_i(OP_SLTI, 2, 13, 16'h0001));         // negative < 1
    send_word(enc_i(OP_SLTI, 10, 14, 16'h8000));        // min int < -32768
    send_word(enc_i(OP_SLTI, 11, 15, 16'h7FFF));        // max int not < 32767
    send_word(enc_i(OP_BEQ, 1, 1, 16'h7FFF));           // taken, far forward
    send_word(enc_i(OP_BEQ, 1, 2, 16'h8000));           // not taken
    send_word(enc_i(OP_BNE, 1, 2, 16'h8000));           // taken, far backward
    send_word(enc_i(OP_BNE, 0, 0, 16'h1234));           // not taken
    send_word({OP_J, 26'h3FF_FFFF});
    send_word({OP_J, 26'h000_0000});
    send_word({6'b000001, 26'h000_0000});               // unknown opcodes
    send_word({6'b111110, 26'h3FF_FFFF});
    send_word(enc_r(31, 31, 31, 31, 6'b111111));        // unknown funct
    send_word({OP_DUMP, 26'h000_0000});
    idle_input();
    wait_for_results();
  endtask

  // random program from a given start address under one idling style
  task automatic test_random_program(input logic [31:0] base_pc, input rx_mode_t rmode,
                                     input bit bursty);
    load_start_pc(base_pc);
    rx_mode   = rmode;
    tx_bursty = bursty;
    repeat (RANDOM_PHASE_WORDS) send_word(random_instr());
    idle_input();
    wait_for_results();
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the output register fills and the input side has to stall
  task automatic test_output_backpressure();
    load_start_pc(32'h0040_0000);
    rx_mode   = RX_ALWAYS;
    tx_bursty = 1'b0;
    hold_reqs++;
    for (int k = 0; k < 24; k++)
      send_word((k % 8 == 3) ? {OP_DUMP, 26'h155_5555} : random_instr());
    idle_input();
    wait_for_results();
  endtask

  // halt word locks the block; everything afterwards, dump and a second halt
  // included, is only acknowledged, and a start_pc write just moves the pc
  task automatic test_halt_lockup();
    load_start_pc(32'h0000_1000);
    rx_mode   = RX_PATTERN;
    tx_bursty = 1'b1;
    send_word(enc_i(OP_ADDI, 3, 3, 16'h0001));
    send_word(HALT_WORD);
    send_word({OP_DUMP, 26'h000_0000});
    send_word(HALT_WORD);
    repeat (8) send_word(random_instr());
    idle_input();
    wait_for_results();
    load_start_pc(32'hFFFF_FFFC);
    repeat (4) send_word(random_instr());
    idle_input();
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    arch_pc   = '0;
    is_halted = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_random_program(32'hFFFF_FFFF, RX_RANDOM, 1'b1);   // unaligned top of space
    test_random_program(32'h0000_0000, RX_ALWAYS, 1'b0);   // no idling at all
    test_random_program($urandom(), RX_PATTERN, 1'b1);
    test_random_program(32'hFFFF_FFFC, RX_RANDOM, 1'b0);   // pc wraps through zero
    test_output_backpressure();
    test_halt_lockup();

    // catch any stray words after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && retire_q.size() == 0)
      $display("mips_subset_execute_unit_top test passed");
    else
      $display("mips_subset_execute_unit_top test failed");
    $finish;
  end

endmodule
